>>> sv/matrix_vector_multiply_macros.svh
// Assertion macros for the matrix-vector product block.
// Expects clk and rst in the scope where the macros are used.
`ifndef MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define MATRIX_VECTOR_MULTIPLY_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define MVM_ASSERT_NOW(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define MVM_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

>>> sv/mvm_pkg.sv
// Shared types and constants of the matrix-vector product block.
// No dependencies; the design files refer to it by scoped names, the testbench files import it.
package mvm_pkg;

  localparam int MAX_VECTOR_LEN = 4096;
  localparam int VALUE_BITS     = 16;
  localparam int INDEX_BITS     = 12;
  localparam int ADDR_BITS      = $clog2(MAX_VECTOR_LEN);
  localparam int PRODUCT_BITS   = 2 * VALUE_BITS;
  localparam int SUM_BITS       = 48;
  localparam int ROW_BITS       = 16;
  localparam int IN_LEN_BITS    = 13;
  localparam int OUT_LEN_BITS   = 17;

  localparam int S_TDATA_BITS   = 32;
  localparam int M_TDATA_BITS   = 64;

  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [IN_LEN_BITS-1:0]  IN_LEN_RESET  = 13'd64;
  localparam logic [OUT_LEN_BITS-1:0] OUT_LEN_RESET = 17'd64;
  localparam logic [IN_LEN_BITS-1:0]  IN_LEN_MAX    = 13'd4096;
  localparam logic [OUT_LEN_BITS-1:0] OUT_LEN_MAX   = 17'd65536;

  localparam logic REG_IN_LEN  = 1'b0;
  localparam logic REG_OUT_LEN = 1'b1;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_WEIGHT = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic                   store_ok;
    logic [INDEX_BITS-1:0]  index;
    logic [VALUE_BITS-1:0]  value;
  } queue_entry_t;

  typedef struct packed {
    logic [QUEUE_CNT_BITS-1:0] count;
  } queue_status_t;

  typedef struct packed {
    logic [IN_LEN_BITS-1:0]  cols;
    logic [OUT_LEN_BITS-1:0] rows;
  } cfg_t;

  typedef struct packed {
    logic                  idle;
    logic                  emit;
    logic [ADDR_BITS-1:0]  col;
    logic [ROW_BITS-1:0]   row;
  } back_status_t;

endpackage

>>> sv/mvm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/mvm_front.sv
// Front end: accepts input requests, classifies them and queues them.
// Depends on mvm_pkg.
module mvm_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata: element_index [11:0], operand_value [27:12], zero pad [31:28]
  input  logic [mvm_pkg::S_TDATA_BITS-1:0]    s_tdata,
  // s_tuser: command [0]
  input  logic                                s_tuser,
  output mvm_pkg::queue_entry_t               head,
  output logic                                head_valid,
  input  logic                                pop,
  output mvm_pkg::queue_status_t              status
);

  mvm_pkg::queue_entry_t                 entries [mvm_pkg::QUEUE_DEPTH];
  mvm_pkg::queue_entry_t                 incoming;
  logic [mvm_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr;
  logic [mvm_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr;
  logic [mvm_pkg::QUEUE_CNT_BITS-1:0]    count;
  logic                                  push;
  logic                                  do_pop;

  // Classify: decode the command and check the store bound once, up front.
  always_comb begin
    incoming.cmd      = mvm_pkg::cmd_t'(s_tuser);
    incoming.index    = s_tdata[mvm_pkg::INDEX_BITS-1:0];
    incoming.value    = s_tdata[mvm_pkg::INDEX_BITS +: mvm_pkg::VALUE_BITS];
    incoming.store_ok = (32'(s_tdata[mvm_pkg::INDEX_BITS-1:0]) < 32'(mvm_pkg::MAX_VECTOR_LEN));
  end

  assign s_tready     = (count != mvm_pkg::QUEUE_CNT_BITS'(mvm_pkg::QUEUE_DEPTH));
  assign push         = s_tvalid && s_tready;
  assign head_valid   = (count != '0);
  assign do_pop       = pop && head_valid;
  assign head         = entries[rd_ptr];
  assign status.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

endmodule

>>> sv/mvm_back.sv
// Back end: vector store, multiply-accumulate sequencer and result register.
// Depends on mvm_pkg and mvm_ram.
module mvm_back (
  input  logic                              clk,
  input  logic                              rst,
  input  mvm_pkg::cfg_t                     cfg,
  input  mvm_pkg::queue_entry_t             head,
  input  logic                              head_valid,
  output logic                              pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata: row_sum [47:0], row_number [63:48]
  output logic [mvm_pkg::M_TDATA_BITS-1:0]  m_tdata,
  // m_tlast: final_row
  output logic                              m_tlast,
  output mvm_pkg::back_status_t             status
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_MAC  = 3'b100
  } state_t;

  state_t                               state;
  logic [mvm_pkg::ADDR_BITS-1:0]        col;
  logic [mvm_pkg::ROW_BITS-1:0]         row;
  logic signed [mvm_pkg::SUM_BITS-1:0]  acc;
  logic signed [mvm_pkg::VALUE_BITS-1:0] weight;
  logic [mvm_pkg::ADDR_BITS-1:0]        col_used;
  logic signed [mvm_pkg::PRODUCT_BITS-1:0] product;
  logic [mvm_pkg::SUM_BITS-1:0]         out_sum;
  logic [mvm_pkg::ROW_BITS-1:0]         out_row;
  logic                                 out_last;
  logic                                 out_valid;

  logic [mvm_pkg::IN_LEN_BITS-1:0]      cols_m1;
  logic [mvm_pkg::ADDR_BITS-1:0]        col_clamp;
  logic [mvm_pkg::VALUE_BITS-1:0]       x_value;
  logic signed [mvm_pkg::SUM_BITS-1:0]  sum;
  logic                                 at_end;
  logic                                 last;
  logic                                 out_free;
  logic                                 emit;
  logic                                 wr_en;
  logic                                 rd_en;

  always_comb begin
    cols_m1   = cfg.cols - 1'b1;
    col_clamp = ({1'b0, col} >= cfg.cols) ? cols_m1[mvm_pkg::ADDR_BITS-1:0] : col;
    pop       = (state == ST_IDLE) && head_valid;
    wr_en     = pop && (head.cmd == mvm_pkg::CMD_LOAD) && head.store_ok;
    rd_en     = pop && (head.cmd == mvm_pkg::CMD_WEIGHT);
    sum       = acc + mvm_pkg::SUM_BITS'(product);
    at_end    = (({1'b0, col_used} + 1'b1) >= cfg.cols);
    last      = (({1'b0, row} + 1'b1) >= cfg.rows);
    out_free  = !out_valid || m_tready;
    emit      = (state == ST_MAC) && at_end && out_free;
  end

  mvm_ram #(
    .WIDTH (mvm_pkg::VALUE_BITS),
    .DEPTH (mvm_pkg::MAX_VECTOR_LEN)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (head.index[mvm_pkg::ADDR_BITS-1:0]),
    .wr_data (head.value),
    .rd_en   (rd_en),
    .rd_addr (col_clamp),
    .rd_data (x_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      col       <= '0;
      row       <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            if (head.cmd == mvm_pkg::CMD_LOAD) begin
              col <= '0;
              row <= '0;
              acc <= '0;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_MAC;
        end
        ST_MAC: begin
          if (!at_end) begin
            acc   <= sum;
            col   <= col_used + 1'b1;
            state <= ST_IDLE;
          end else if (out_free) begin
            acc   <= '0;
            col   <= '0;
            row   <= last ? '0 : row + 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      weight   <= $signed(head.value);
      col_used <= col_clamp;
    end
    if (state == ST_READ) begin
      product <= weight * $signed(x_value);
    end
    if (emit) begin
      out_sum  <= sum;
      out_row  <= row;
      out_last <= last;
    end
  end

  assign m_tvalid    = out_valid;
  assign m_tdata     = {out_row, out_sum};
  assign m_tlast     = out_last;
  assign status.idle = (state == ST_IDLE);
  assign status.emit = emit;
  assign status.col  = col;
  assign status.row  = row;

endmodule

>>> sv/matrix_vector_multiply.sv
// Top level of the matrix-vector product block: register port, front and back.
// Depends on mvm_pkg, mvm_front, mvm_back and matrix_vector_multiply_macros.svh.
//
// Usage: requests enter on the s_* stream. s_tuser is the command: load writes
// operand_value into the vector store at element_index and restarts the
// product; weight multiplies operand_value by the stored element at the current
// column and adds it to the row sum. After in_len weights the row sum leaves on
// the m_* stream with its row number; m_tlast marks the last of out_len rows.
// With the queue empty, a row's last weight goes through the weight and store
// read registers and the product register into the result register. The back
// end handles a load in its idle state and a weight in store read, registered
// multiply and accumulate steps, popping no new request until done, so this
// sequence sets the weight rate, and a 4-entry queue decouples intake from it.
// Reset: in_len and out_len return to 64, counters and the sum clear; the
// vector store is undefined until loaded, with no clearing pass.
// Stalls: while m_tready is low the result holds; the back end keeps working
// until it needs to post another result, and s_tready drops when the queue fills.
// Registers (APB, pready always high): in_len at 0x0, out_len at 0x4.
`include "matrix_vector_multiply_macros.svh"

module matrix_vector_multiply (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata: element_index [11:0], operand_value [27:12], zero pad [31:28]
  input  logic [mvm_pkg::S_TDATA_BITS-1:0]  s_tdata,
  // s_tuser: command [0]
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata: row_sum [47:0], row_number [63:48]
  output logic [mvm_pkg::M_TDATA_BITS-1:0]  m_tdata,
  // m_tlast: final_row
  output logic                              m_tlast
);

  logic [mvm_pkg::IN_LEN_BITS-1:0]  in_len;
  logic [mvm_pkg::OUT_LEN_BITS-1:0] out_len;
  logic                             cfg_write;
  mvm_pkg::cfg_t                    cfg;
  mvm_pkg::queue_entry_t            head;
  logic                             head_valid;
  logic                             pop;
  mvm_pkg::queue_status_t           front_status;
  mvm_pkg::back_status_t            back_status;
  logic                             result_free;
  logic                             load_popped;
  logic                             counters_zero;
  logic                             queue_in_bound;

  // Register port: word select on paddr[2], byte offset ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_len  <= mvm_pkg::IN_LEN_RESET;
      out_len <= mvm_pkg::OUT_LEN_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        mvm_pkg::REG_IN_LEN:  in_len  <= pwdata[mvm_pkg::IN_LEN_BITS-1:0];
        mvm_pkg::REG_OUT_LEN: out_len <= pwdata[mvm_pkg::OUT_LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mvm_pkg::REG_IN_LEN:  prdata = 32'(in_len);
      mvm_pkg::REG_OUT_LEN: prdata = 32'(out_len);
      default:              prdata = '0;
    endcase
  end

  // Effective lengths: zero acts as one, oversize saturates.
  always_comb begin
    if (in_len == '0) begin
      cfg.cols = mvm_pkg::IN_LEN_BITS'(1);
    end else if (in_len > mvm_pkg::IN_LEN_MAX) begin
      cfg.cols = mvm_pkg::IN_LEN_MAX;
    end else begin
      cfg.cols = in_len;
    end
    if (out_len == '0) begin
      cfg.rows = mvm_pkg::OUT_LEN_BITS'(1);
    end else if (out_len > mvm_pkg::OUT_LEN_MAX) begin
      cfg.rows = mvm_pkg::OUT_LEN_MAX;
    end else begin
      cfg.rows = out_len;
    end
  end

  mvm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .status     (front_status)
  );

  mvm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .status     (back_status)
  );

  assign result_free    = !m_tvalid || m_tready;
  assign load_popped    = pop && (head.cmd == mvm_pkg::CMD_LOAD);
  assign counters_zero  = (back_status.col == '0) && (back_status.row == '0);
  assign queue_in_bound =
    (front_status.count <= mvm_pkg::QUEUE_CNT_BITS'(mvm_pkg::QUEUE_DEPTH));

  // Never overwrite a result that the receiver has not taken.
  `MVM_ASSERT_NOW(a_emit_free, back_status.emit, result_free, "result overwritten")
  // A new result appears only from a posted row sum.
  `MVM_ASSERT_NOW(a_valid_from_emit, $rose(m_tvalid), $past(back_status.emit), "spurious result")
  // A load restarts the product at row 0, column 0.
  `MVM_ASSERT_NEXT(a_load_clears, load_popped, counters_zero, "load did not clear counters")
  // The queue stays within its depth.
  `MVM_ASSERT_NOW(a_queue_bound, 1'b1, queue_in_bound, "queue overflow")

endmodule

>>> dv/matrix_vector_multiply_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the matrix-vector product block: tracks register writes,
// predicts row sums from accepted requests and compares them. Needs mvm_pkg.
module mvm_product_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);
  import mvm_pkg::*;

  typedef struct packed {
    logic [SUM_BITS-1:0] row_sum;
    logic [ROW_BITS-1:0] row_number;
    logic                final_row;
  } row_result_t;

  logic signed [VALUE_BITS-1:0] vec_store [MAX_VECTOR_LEN];
  logic [IN_LEN_BITS-1:0]       in_len_q;
  logic [OUT_LEN_BITS-1:0]      out_len_q;
  int unsigned                  col_count;
  int unsigned                  row_count;
  logic [SUM_BITS-1:0]          row_sum_acc;
  row_result_t                  expected_rows [$];
  int                           errors = 0;

  assign fail_count = errors;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // Advance the predicted datapath by one accepted request.
  task automatic apply_request(input logic cmd, input logic [INDEX_BITS-1:0] index,
                               input logic signed [VALUE_BITS-1:0] value);
    int unsigned cols;
    int unsigned rows;
    int unsigned col;
    logic signed [VALUE_BITS-1:0] element;
    logic signed [PRODUCT_BITS-1:0] product;
    row_result_t res;
    if (cmd == CMD_LOAD) begin
      vec_store[index] = value;
      col_count = 0;
      row_count = 0;
      row_sum_acc = '0;
    end else begin
      cols = (in_len_q == 0) ? 1 : ((in_len_q > MAX_VECTOR_LEN) ? MAX_VECTOR_LEN : in_len_q);
      rows = (out_len_q == 0) ? 1 : ((out_len_q > 65536) ? 65536 : out_len_q);
      col = (col_count >= cols) ? cols - 1 : col_count;
      element = vec_store[col];
      product = value * element;
      row_sum_acc = row_sum_acc + {{(SUM_BITS - PRODUCT_BITS){product[PRODUCT_BITS-1]}}, product};
      if (col + 1 < cols) begin
        col_count = col + 1;
      end else begin
        res.row_sum = row_sum_acc;
        res.row_number = row_count[ROW_BITS-1:0];
        res.final_row = (row_count + 1 >= rows);
        expected_rows.push_back(res);
        row_sum_acc = '0;
        col_count = 0;
        row_count = res.final_row ? 0 : ((row_count + 1) & 32'hFFFF);
      end
    end
  endtask

  always @(posedge clk) begin
    row_result_t head;
    logic [31:0] reg_value;
    if (rst) begin
      in_len_q = IN_LEN_RESET;
      out_len_q = OUT_LEN_RESET;
      col_count = 0;
      row_count = 0;
      row_sum_acc = '0;
      expected_rows.delete();
    end else begin
      // Register port: shadow writes, check reads against the shadow.
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_IN_LEN) in_len_q = pwdata[IN_LEN_BITS-1:0];
          else out_len_q = pwdata[OUT_LEN_BITS-1:0];
        end else begin
          reg_value = (paddr[2] == REG_IN_LEN) ? 32'(in_len_q) : 32'(out_len_q);
          if (prdata !== reg_value)
            report_mismatch($sformatf("register 0x%0h read 0x%0h, want 0x%0h",
                                      paddr, prdata, reg_value));
        end
      end
      if (m_tvalid && m_tready) begin
        if (expected_rows.size() == 0) begin
          report_mismatch($sformatf("unexpected row sum 0x%0h", m_tdata));
        end else begin
          head = expected_rows.pop_front();
          if (m_tdata[47:0] !== head.row_sum)
            report_mismatch($sformatf("row %0d sum 0x%0h, want 0x%0h",
                                      head.row_number, m_tdata[47:0], head.row_sum));
          if (m_tdata[63:48] !== head.row_number)
            report_mismatch($sformatf("row number %0d, want %0d",
                                      m_tdata[63:48], head.row_number));
          if (m_tlast !== head.final_row)
            report_mismatch($sformatf("row %0d last flag %b, want %b",
                                      head.row_number, m_tlast, head.final_row));
        end
      end
      if (s_tvalid && s_tready)
        apply_request(s_tuser, s_tdata[11:0], s_tdata[27:12]);
    end
    pending <= expected_rows.size();
  end

endmodule

>>> dv/matrix_vector_multiply_test.sv
`timescale 1ns / 1ps
// Stimulus top for the matrix-vector product block: clock, reset, register
// programming and request streams. Needs mvm_pkg, matrix_vector_multiply and mvm_product_checker.
module matrix_vector_multiply_test;
  import mvm_pkg::*;

  localparam int          CYCLE_LIMIT   = 1_000_000;
  localparam int          SETTLE_CYCLES = 32;    // queue drain plus pipeline depth
  localparam int          RANDOM_ITEMS  = 850;
  localparam int          LONG_COLS     = 64;
  localparam logic [2:0]  ADDR_IN_LEN   = {REG_IN_LEN, 2'b00};
  localparam logic [2:0]  ADDR_OUT_LEN  = {REG_OUT_LEN, 2'b00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int burst_left = 0;
  int requests_sent = 0;
  int cur_in_len = IN_LEN_RESET;
  bit vec_written [MAX_VECTOR_LEN];

  // Receiver pattern state.
  int ready_mode = 0;
  int mode_left = 0;
  int stall_run = 0;

  always #5 clk = ~clk;

  matrix_vector_multiply u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  mvm_product_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  // Hard stop: a hung handshake or a lost row sum ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side backpressure: switch at random between always ready, coin flips
  // and long stall runs.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_run > 0) begin
          stall_run--;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(1, 20);
        end
      end
    endcase
  end

  // Effective column count as the block sees a given in_len value.
  function automatic int columns_used(input int len);
    if (len == 0) return 1;
    if (len > MAX_VECTOR_LEN) return MAX_VECTOR_LEN;
    return len;
  endfunction

  // Weight or vector value: mostly random, sometimes an extreme.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Send one request; hold it until accepted. Between bursts drop valid for
  // a random gap, or keep streaming when the gap comes out zero.
  task automatic send_request(input cmd_t cmd, input logic [11:0] index,
                              input logic [15:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {4'b0000, value, index};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    burst_left--;
    requests_sent++;
    if (cmd == CMD_LOAD) vec_written[index] = 1'b1;
  endtask

  task automatic send_weight(input logic [15:0] value);
    send_request(CMD_WEIGHT, 12'($urandom), value);
  endtask

  // Drop valid, wait for every pending row sum, then let queued requests
  // that carry no result drain before touching the registers.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (addr == ADDR_IN_LEN) cur_in_len = data[IN_LEN_BITS-1:0];
  endtask

  task automatic read_register(input logic [2:0] addr);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Make sure every column the next weights can read has been loaded.
  task automatic fill_vector();
    for (int i = 0; i < columns_used(cur_in_len); i++)
      if (!vec_written[i] || $urandom_range(0, 5) == 0)
        send_request(CMD_LOAD, 12'(i), pick_value());
  endtask

  // One random phase: new lengths, a vector, then whole rows with some
  // stray loads mixed in and sometimes a row left unfinished.
  task automatic run_product_phase();
    int cols;
    int rows;
    logic [31:0] len;
    wait_idle();
    case ($urandom_range(0, 9))
      0: len = 0;
      8: len = $urandom_range(9, 40);
      9: len = cur_in_len;
      default: len = $urandom_range(1, 8);
    endcase
    if (len != cur_in_len || $urandom_range(0, 1) == 0) write_register(ADDR_IN_LEN, len);
    case ($urandom_range(0, 11))
      0: len = 0;
      1: len = $urandom_range(6, 300);
      2: len = $urandom_range(65530, 131071);
      default: len = $urandom_range(1, 5);
    endcase
    write_register(ADDR_OUT_LEN, len);
    read_register($urandom_range(0, 1) ? ADDR_IN_LEN : ADDR_OUT_LEN);
    cols = columns_used(cur_in_len);
    if ($urandom_range(0, 2) != 0) fill_vector();
    else begin
      for (int i = 0; i < cols; i++)
        if (!vec_written[i]) send_request(CMD_LOAD, 12'(i), pick_value());
    end
    rows = $urandom_range(1, 6);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        // Stray load: restarts the product at row 0, column 0.
        if ($urandom_range(0, 39) == 0) send_request(CMD_LOAD, 12'($urandom), pick_value());
        send_weight(pick_value());
      end
    end
    // Sometimes add up to a row of extra weights, so the next lengths can apply mid-row.
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, cols)) send_weight(pick_value());
  endtask

  initial begin
    int random_start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values of both registers.
    read_register(ADDR_IN_LEN);
    read_register(ADDR_OUT_LEN);

    // Directed: extreme operands over a 4 x 2 product.
    write_register(ADDR_IN_LEN, 4);
    write_register(ADDR_OUT_LEN, 2);
    send_request(CMD_LOAD, 12'd0, 16'h8000);
    send_request(CMD_LOAD, 12'd1, 16'h7FFF);
    send_request(CMD_LOAD, 12'd2, 16'hFFFF);
    send_request(CMD_LOAD, 12'd3, 16'h0001);
    send_weight(16'h8000);
    send_weight(16'h8000);
    send_weight(16'h7FFF);
    send_weight(16'h0001);
    send_weight(16'h7FFF);
    send_weight(16'h7FFF);
    send_weight(16'hFFFF);
    send_weight(16'h0000);
    // Load in the middle of a row restarts the product; top store index too.
    send_weight(16'h0100);
    send_request(CMD_LOAD, 12'hFFF, 16'h7FFF);
    send_weight(16'h0200);
    send_weight(16'hFF00);
    send_weight(16'h1234);
    // Shrink the row length under a row in progress: the next weight ends it.
    wait_idle();
    write_register(ADDR_IN_LEN, 2);
    send_weight(16'h0080);
    // Zero lengths act as one: every weight is a whole, final row.
    wait_idle();
    write_register(ADDR_IN_LEN, 0);
    write_register(ADDR_OUT_LEN, 0);
    send_weight(16'h8000);
    send_weight(16'h7FFF);
    send_weight(16'h0001);

    // Oversized in_len saturates far above the row so far: no sum may appear
    // yet. A row length of one column more than the row so far then closes it on the next weight.
    wait_idle();
    write_register(ADDR_IN_LEN, 13'h1FFF);
    write_register(ADDR_OUT_LEN, 1);
    read_register(ADDR_IN_LEN);
    for (int i = 0; i <= LONG_COLS; i++) send_request(CMD_LOAD, 12'(i), pick_value());
    repeat (LONG_COLS) send_weight(pick_value());
    wait_idle();
    write_register(ADDR_IN_LEN, LONG_COLS + 1);
    read_register(ADDR_IN_LEN);
    send_weight(pick_value());

    // Row count with the largest out_len values, one column per row.
    wait_idle();
    write_register(ADDR_IN_LEN, 1);
    write_register(ADDR_OUT_LEN, 17'h1FFFF);
    read_register(ADDR_OUT_LEN);
    repeat (4) send_weight(pick_value());
    wait_idle();
    write_register(ADDR_OUT_LEN, 65536);
    repeat (3) send_weight(pick_value());

    random_start = requests_sent;
    while (requests_sent - random_start < RANDOM_ITEMS) run_product_phase();

    wait_idle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/mvm_pkg.sv
sv/mvm_ram.sv
sv/mvm_front.sv
sv/mvm_back.sv
sv/matrix_vector_multiply.sv
dv/matrix_vector_multiply_checker.sv
dv/matrix_vector_multiply_test.sv
